FILE: rtl/fsd_pkg.sv
`timescale 1ns / 1ps

package fsd_pkg;

  // pattern capacity and derived widths
  localparam int MaxPattern = 64;
  localparam int CostW      = $clog2(MaxPattern + 1);
  localparam int IdxW       = $clog2(MaxPattern);
  localparam int SymW       = 8;

  // transaction codes
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_FINISH = 2'd3
  } act_e;

  // text transaction travelling down the row of cells
  typedef struct packed {
    logic             vld;
    logic [SymW-1:0]  sym;
    logic [CostW-1:0] exact;  // cost with last pattern char matched, from left neighbor
    logic [CostW-1:0] diag;   // left neighbor's column entry before this char
    logic [CostW-1:0] res;    // full-pattern cost, captured at the last pattern cell
  } tok_t;

  // control broadcast to every cell
  typedef struct packed {
    logic             restart;
    logic             append;
    logic [SymW-1:0]  sym;
    logic [CostW-1:0] len;
  } ctl_t;

  // increment that saturates at the pattern capacity
  function automatic logic [CostW-1:0] sat_inc(input logic [CostW-1:0] x);
    logic [CostW-1:0] r;
    if (x >= CostW'(MaxPattern)) r = CostW'(MaxPattern);
    else r = x + 1'b1;
    return r;
  endfunction

endpackage

FILE: rtl/fsd_cell.sv
`timescale 1ns / 1ps

module fsd_cell import fsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CostW-1:0] idx_i,
  input  ctl_t             ctl_i,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic [SymW-1:0]  pat_q;
  logic [CostW-1:0] col_q, col_d;
  logic             col_vld_q;
  logic [CostW-1:0] col;
  logic [CostW-1:0] m;
  logic [CostW-1:0] cand;
  logic             vld_q;
  logic [SymW-1:0]  sym_q;
  logic [CostW-1:0] exact_q;
  logic [CostW-1:0] diag_q;
  logic [CostW-1:0] res_q;

  // column entry reads as its index until first written after a restart
  assign col = col_vld_q ? col_q : idx_i;

  // cost of prefix ending in a match, and new column entry
  always_comb begin
    m = sat_inc(tok_i.exact);
    if (pat_q == tok_i.sym && tok_i.diag < m) m = tok_i.diag;
    cand = sat_inc(col);
    if (m < cand) cand = m;
    if (idx_i < cand) cand = idx_i;
    col_d = cand;
  end

  // pattern char of this cell, written when it is the next free slot
  always_ff @(posedge clk_i) begin
    if (ctl_i.append && ctl_i.len == idx_i - 1'b1) begin
      pat_q <= ctl_i.sym;
    end
  end

  // column entry and hand-off register to the right neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_vld_q <= 1'b0;
      vld_q     <= 1'b0;
    end else if (ctl_i.restart) begin
      col_vld_q <= 1'b0;
      vld_q     <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
      if (tok_i.vld) begin
        col_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.vld) begin
      col_q   <= col_d;
      sym_q   <= tok_i.sym;
      exact_q <= m;
      diag_q  <= col;
      res_q   <= (idx_i == ctl_i.len) ? m : tok_i.res;
    end
  end

  assign tok_o = '{vld: vld_q, sym: sym_q, exact: exact_q, diag: diag_q, res: res_q};

endmodule

FILE: rtl/fuzzy_substring_distance.sv
`timescale 1ns / 1ps
// Fuzzy substring distance: least indel cost of fitting a pattern into any
// substring of a text (leading and trailing text free, no substitutions).
// Input channel: action_i and symbol_i are taken when start is high and busy
// is low. Action clear empties the pattern, append adds symbol_i to the
// pattern, text streams one text char, finish requests the result.
// Clear, append and text transactions are taken one per cycle while busy is
// low. Each text char walks a row of MaxPattern cells, registered in each
// cell, so its effect reaches the best cost once it leaves the last cell.
// After a finish, busy stays high until the row holds no text char, then
// done_o pulses for one cycle with difference_o and overflow_o; the wait
// is set by how recently the last text char was taken.
// Clear, append and the result of a finish restart the scan: the cost column
// returns to its initial values and any text still in the row is dropped.
// The receiver cannot stall; a result is valid only in the done_o cycle.
// Reset empties the pattern, clears the overflow flag and the scan.

module fuzzy_substring_distance import fsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action_i,
  input  logic [SymW-1:0]  symbol_i,
  output logic             done_o,
  output logic [6:0]       difference_o,
  output logic             overflow_o
);

  act_e             act;
  logic             accept;
  logic             emit;
  logic             restart;
  logic             any_vld;
  logic [CostW-1:0] len_q, len_d;
  logic [CostW-1:0] best_q;
  logic             ovf_q, ovf_d;
  logic             pend_q;
  logic             done_q;
  logic [6:0]       diff_q;
  logic             ovf_out_q;
  logic             room;
  ctl_t             ctl;
  tok_t             tok_w [MaxPattern+1];
  logic [MaxPattern-1:0] vld_w;

  assign act     = act_e'(action_i);
  assign accept  = start && !pend_q;
  assign any_vld = |vld_w;
  assign emit    = pend_q && !any_vld;
  assign room    = len_q < CostW'(MaxPattern);
  assign restart = emit || (accept && (act == ACT_CLEAR || act == ACT_APPEND));

  // next pattern length and overflow flag
  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (accept) begin
      case (act)
        ACT_CLEAR: begin
          len_d = '0;
          ovf_d = 1'b0;
        end
        ACT_APPEND: begin
          if (room) len_d = len_q + 1'b1;
          else ovf_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // control broadcast to the cells
  always_comb begin
    ctl.restart = restart;
    ctl.append  = accept && act == ACT_APPEND && room;
    ctl.sym     = symbol_i;
    ctl.len     = len_q;
  end

  // text transaction entering the first cell
  always_comb begin
    tok_w[0].vld   = accept && act == ACT_TEXT;
    tok_w[0].sym   = symbol_i;
    tok_w[0].exact = CostW'(MaxPattern);
    tok_w[0].diag  = '0;
    tok_w[0].res   = '0;
  end

  // row of cells, one per pattern position
  for (genvar k = 1; k <= MaxPattern; k++) begin : g_cell
    fsd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (CostW'(k)),
      .ctl_i  (ctl),
      .tok_i  (tok_w[k-1]),
      .tok_o  (tok_w[k])
    );
    assign vld_w[k-1] = tok_w[k].vld;
  end

  // pattern state, best cost and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      ovf_q     <= 1'b0;
      best_q    <= '0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
      diff_q    <= '0;
      ovf_out_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      done_q <= emit;
      if (emit) begin
        diff_q    <= 7'(best_q);
        ovf_out_q <= ovf_q;
      end
      if (accept && act == ACT_FINISH) pend_q <= 1'b1;
      else if (emit) pend_q <= 1'b0;
      if (restart) begin
        best_q <= len_d;
      end else if (tok_w[MaxPattern].vld && len_q != '0 &&
                   tok_w[MaxPattern].res < best_q) begin
        best_q <= tok_w[MaxPattern].res;
      end
    end
  end

  assign busy         = pend_q;
  assign done_o       = done_q;
  assign difference_o = diff_q;
  assign overflow_o   = ovf_out_q;

endmodule
